// ===== src/ftl_pkg.sv =====
`timescale 1ns / 1ps

package ftl_pkg;

  localparam int NUM_POINTS = 5;
  localparam int COORD_BITS = 10;
  localparam int NUM_COORDS = 2 * NUM_POINTS;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int CNT_BITS   = 6;
  localparam int PCNT_BITS  = 3;
  localparam int START_BITS = 4;
  localparam int CFG_BITS   = 10;
  localparam int CFG_IDX_BITS = 2;

  // register reset values and the counter ceiling
  localparam logic [COORD_BITS-1:0] LIMIT_RESET = COORD_BITS'(100);
  localparam logic [START_BITS-1:0] START_RESET = START_BITS'(3);
  localparam logic [CNT_BITS-1:0]   MAX_RESET   = CNT_BITS'(20);
  localparam logic [CNT_BITS-1:0]   CNT_CEIL    = '1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_LIMIT  = 2'd1,
    CFG_START  = 2'd2,
    CFG_MAX    = 2'd3
  } cfg_idx_t;

  typedef logic [NUM_COORDS-1:0][COORD_BITS-1:0] coord_arr_t;

  typedef struct packed {
    logic [PCNT_BITS-1:0]  point_count;
    logic [COORD_BITS-1:0] p0_x;
    logic [COORD_BITS-1:0] p0_y;
    logic [COORD_BITS-1:0] p1_x;
    logic [COORD_BITS-1:0] p1_y;
    logic [COORD_BITS-1:0] p2_x;
    logic [COORD_BITS-1:0] p2_y;
    logic [COORD_BITS-1:0] p3_x;
    logic [COORD_BITS-1:0] p3_y;
    logic [COORD_BITS-1:0] p4_x;
    logic [COORD_BITS-1:0] p4_y;
  } frame_t;

  typedef struct packed {
    logic                  locked;
    logic [CNT_BITS-1:0]   frame_score;
    logic [COORD_BITS-1:0] h0_x;
    logic [COORD_BITS-1:0] h0_y;
    logic [COORD_BITS-1:0] h1_x;
    logic [COORD_BITS-1:0] h1_y;
    logic [COORD_BITS-1:0] h2_x;
    logic [COORD_BITS-1:0] h2_y;
    logic [COORD_BITS-1:0] h3_x;
    logic [COORD_BITS-1:0] h3_y;
    logic [COORD_BITS-1:0] h4_x;
    logic [COORD_BITS-1:0] h4_y;
  } result_t;

  function automatic coord_arr_t frame_coords(frame_t f);
    coord_arr_t c;
    c[0] = f.p0_x;
    c[1] = f.p0_y;
    c[2] = f.p1_x;
    c[3] = f.p1_y;
    c[4] = f.p2_x;
    c[5] = f.p2_y;
    c[6] = f.p3_x;
    c[7] = f.p3_y;
    c[8] = f.p4_x;
    c[9] = f.p4_y;
    return c;
  endfunction

  function automatic result_t make_result(logic lck, logic [CNT_BITS-1:0] cnt,
                                          coord_arr_t c);
    result_t r;
    r.locked      = lck;
    r.frame_score = cnt;
    r.h0_x = c[0];
    r.h0_y = c[1];
    r.h1_x = c[2];
    r.h1_y = c[3];
    r.h2_x = c[4];
    r.h2_y = c[5];
    r.h3_x = c[6];
    r.h3_y = c[7];
    r.h4_x = c[8];
    r.h4_y = c[9];
    return r;
  endfunction

endpackage

// ===== src/ftl_if.sv =====
`timescale 1ns / 1ps

interface ftl_in_if;
  logic            valid;
  logic            ready;
  ftl_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ftl_out_if;
  logic             valid;
  logic             ready;
  ftl_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ftl_dist_check.sv =====
`timescale 1ns / 1ps

module ftl_dist_check (
  input  ftl_pkg::coord_arr_t              new_pts,
  input  ftl_pkg::coord_arr_t              held_pts,
  input  logic [ftl_pkg::SQ_BITS-1:0]      lim2,
  output logic                             close
);

  logic [ftl_pkg::NUM_POINTS-1:0] far;

  // one lane per point: squared distance against the squared limit
  always_comb begin
    logic [ftl_pkg::COORD_BITS-1:0] dx;
    logic [ftl_pkg::COORD_BITS-1:0] dy;
    logic [ftl_pkg::SQ_BITS:0]      d2;
    for (int i = 0; i < ftl_pkg::NUM_POINTS; i++) begin
      dx = (new_pts[2*i] > held_pts[2*i]) ? new_pts[2*i] - held_pts[2*i]
                                          : held_pts[2*i] - new_pts[2*i];
      dy = (new_pts[2*i+1] > held_pts[2*i+1]) ? new_pts[2*i+1] - held_pts[2*i+1]
                                              : held_pts[2*i+1] - new_pts[2*i+1];
      d2 = {1'b0, ftl_pkg::SQ_BITS'(dx * dx)} + {1'b0, ftl_pkg::SQ_BITS'(dy * dy)};
      far[i] = d2 > {1'b0, lim2};
    end
  end

  assign close = ~|far;

endmodule

// ===== src/fingertip_track_lock_top.sv =====
`timescale 1ns / 1ps

// channel   | dir | handshake            | payload
// ----------+-----+----------------------+----------------------------------------
// in_frame  | in  | valid/ready          | point_count, p0_x .. p4_y
// out_lock  | out | valid/ready          | locked, frame_score, h0_x .. h4_y
// cfg       | in  | cfg_we, no wait      | cfg_idx, cfg_wdata
//
// one transaction per cycle sustained while out_lock is ready; each transaction passes through
// the input register, then the distance check and counter update into the result register
// rst_n is synchronous active low and clears valids, lock state, counter, held points
// and the configuration registers to their defaults
// a stalled result register holds the next transaction in the input register; the
// tracker state only advances when a transaction moves into the result register

module fingertip_track_lock_top (
  input  logic                                clk,
  input  logic                                rst_n,
  ftl_in_if.sink                              in_frame,
  ftl_out_if.source                           out_lock,
  input  logic                                cfg_we,
  input  logic [ftl_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [ftl_pkg::CFG_BITS-1:0]        cfg_wdata
);

  // configuration registers; the limit is kept already squared
  logic                              enable_r;
  logic [ftl_pkg::SQ_BITS-1:0]       lim2_r;
  logic [ftl_pkg::START_BITS-1:0]    start_r;
  logic [ftl_pkg::CNT_BITS-1:0]      max_r;

  // input register
  logic                              s1_valid_r;
  ftl_pkg::frame_t                   s1_data_r;

  // tracker state
  logic                              lock_r, lock_nxt;
  logic [ftl_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;
  ftl_pkg::coord_arr_t               held_r, held_nxt;

  // result register
  logic                              out_valid_r;
  ftl_pkg::result_t                  out_data_r;

  logic                              s1_adv;
  logic                              full;
  logic                              close;
  ftl_pkg::coord_arr_t               pts;
  logic [ftl_pkg::CNT_BITS:0]        cnt_inc1;
  logic [ftl_pkg::CNT_BITS:0]        cnt_inc2;
  logic [ftl_pkg::CNT_BITS-1:0]      cnt_dec;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      lim2_r   <= ftl_pkg::SQ_BITS'(ftl_pkg::LIMIT_RESET * ftl_pkg::LIMIT_RESET);
      start_r  <= ftl_pkg::START_RESET;
      max_r    <= ftl_pkg::MAX_RESET;
    end else if (cfg_we) begin
      case (ftl_pkg::cfg_idx_t'(cfg_idx))
        ftl_pkg::CFG_ENABLE: enable_r <= cfg_wdata[0];
        ftl_pkg::CFG_LIMIT: begin
          lim2_r <= ftl_pkg::SQ_BITS'(cfg_wdata[ftl_pkg::COORD_BITS-1:0] *
                                      cfg_wdata[ftl_pkg::COORD_BITS-1:0]);
        end
        ftl_pkg::CFG_START: start_r <= cfg_wdata[ftl_pkg::START_BITS-1:0];
        ftl_pkg::CFG_MAX:   max_r   <= cfg_wdata[ftl_pkg::CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register is free
  assign s1_adv         = s1_valid_r && (!out_valid_r || out_lock.ready);
  assign in_frame.ready = !s1_valid_r || s1_adv;
  assign out_lock.valid = out_valid_r;
  assign out_lock.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_frame.ready) begin
      s1_valid_r <= in_frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_frame.ready && in_frame.valid) begin
      s1_data_r <= in_frame.data;
    end
  end

  assign pts  = ftl_pkg::frame_coords(s1_data_r);
  assign full = s1_data_r.point_count == ftl_pkg::PCNT_BITS'(ftl_pkg::NUM_POINTS);

  ftl_dist_check u_dist (
    .new_pts  (pts),
    .held_pts (held_r),
    .lim2     (lim2_r),
    .close    (close)
  );

  assign cnt_inc1 = {1'b0, cnt_r} + (ftl_pkg::CNT_BITS+1)'(1);
  assign cnt_inc2 = {1'b0, cnt_r} + (ftl_pkg::CNT_BITS+1)'(2);
  // a bad frame at zero stays at zero
  assign cnt_dec  = (cnt_r != '0) ? cnt_r - ftl_pkg::CNT_BITS'(1) : cnt_r;

  // tracker update for the frame in the input register
  always_comb begin
    lock_nxt = lock_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    if (enable_r) begin
      if (lock_r) begin
        if (full && close) begin
          held_nxt = pts;
          if (cnt_r < max_r) begin
            // saturate at the top of the counter range
            cnt_nxt = cnt_inc2[ftl_pkg::CNT_BITS] ? ftl_pkg::CNT_CEIL
                                                  : cnt_inc2[ftl_pkg::CNT_BITS-1:0];
          end
        end else begin
          cnt_nxt  = cnt_dec;
          lock_nxt = cnt_dec != '0;
        end
      end else if (!full) begin
        cnt_nxt = '0;
      end else if (cnt_r == '0) begin
        // first frame of an acquisition seeds the held set
        held_nxt = pts;
        cnt_nxt  = ftl_pkg::CNT_BITS'(1);
      end else if (close) begin
        held_nxt = pts;
        if (cnt_inc1 >= (ftl_pkg::CNT_BITS+1)'(start_r)) begin
          lock_nxt = 1'b1;
          cnt_nxt  = max_r;
        end else begin
          cnt_nxt = cnt_inc1[ftl_pkg::CNT_BITS-1:0];
        end
      end else begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b0;
      cnt_r  <= '0;
      held_r <= '0;
    end else if (s1_adv) begin
      lock_r <= lock_nxt;
      cnt_r  <= cnt_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_lock.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= ftl_pkg::make_result(lock_nxt, cnt_nxt, held_nxt);
    end
  end

endmodule
